/* hdl/cfd_pkg.sv */
// Shared constants for the checksummed frame deframer.
// No dependencies.
`default_nettype none
package cfd_pkg;
  localparam int unsigned StoreDepth = 261;
  localparam int unsigned AddrBits   = 9;
  localparam int unsigned FixedBytes = 6;
  localparam int unsigned HdrBytes   = 4;
  localparam int unsigned OutBits    = 144;
  localparam logic [7:0]  SyncReset  = 8'hAA;
endpackage
`default_nettype wire

/* hdl/checksummed_frame_deframer.sv */
// Checksummed frame deframer top level.
// Depends on cfd_pkg.
// Usage:
//  - s_axis carries one received link byte per request (tdata[7:0]).
//  - cfg_* writes the sync byte (reset value 0xAA); write only when idle.
//  - m_axis gives one request per payload word of an accepted frame.
//    tlast marks the final word of a frame. An empty payload yields one
//    word with word_bytes 0.
//  - Bytes sit in a 512-entry circular buffer (one write, one read port,
//    registered read). Each buffer read has an address step and a data step.
//  - Per input byte: the byte is stored, bytes that are not the sync byte
//    are dropped one buffer read each while hunting sync, and the header
//    is read. A complete frame is read once for the checksums and once
//    more for the payload, and each word is handed out in turn. A failed
//    check drops one byte and rescans, which may hold s_axis_tready low
//    a while.
//  - Input is taken only while no frame is being processed.
//  - When m_axis_tready is low, hold the current word and stall.
//  - Reset empties the buffer and clears the rejection counter; no
//    clearing pass is needed.
`default_nettype none
module checksummed_frame_deframer
  import cfd_pkg::*;
#(
  parameter int unsigned COUNTER_BITS = 32
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [7:0]         cfg_data_i,   // sync_byte
  input  wire logic               s_axis_tvalid,
  output logic                    s_axis_tready,
  input  wire logic [7:0]         s_axis_tdata, // rx_byte
  output logic                    m_axis_tvalid,
  input  wire logic               m_axis_tready,
  // frame_address[7:0], frame_id[15:8], payload_length[23:16],
  // data_word[87:24], word_bytes[91:88], byte-sum check[99:92],
  // sum-of-sums check[107:100], rejected_count[139:108], zero[143:140]
  output logic [OutBits-1:0]      m_axis_tdata,
  output logic                    m_axis_tlast  // last_word
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_HDR  = 3'd2;
  localparam logic [2:0] S_SUM  = 3'd3;
  localparam logic [2:0] S_CHK  = 3'd4;
  localparam logic [2:0] S_WORD = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  logic [7:0] mem [2**AddrBits];

  logic [2:0]              state_q, state_d;
  logic                    phase_q, phase_d;
  logic [AddrBits-1:0]     head_q, head_d, fill_q, fill_d, idx_q, idx_d;
  logic [7:0]              sync_q, addr_q, addr_d, id_q, id_d, len_q, len_d;
  logic [7:0]              sum_q, sum_d, add_q, add_d, chks_q, chks_d, chka_q, chka_d;
  logic [7:0]              pos_q, pos_d;
  logic [3:0]              wcnt_q, wcnt_d;
  logic [63:0]             word_q, word_d;
  logic                    last_q, last_d;
  logic [COUNTER_BITS-1:0] rej_q, rej_d;
  logic [7:0]              rd_data_q;
  logic [AddrBits-1:0]     rd_addr, wr_addr, fsize, data_fsize;
  logic [7:0]              sum_nx;
  logic                    wr_en;

  assign rd_addr     = head_q + idx_q;
  assign wr_addr     = head_q + fill_q;
  assign fsize       = {1'b0, len_q} + AddrBits'(FixedBytes);
  assign data_fsize  = {1'b0, rd_data_q} + AddrBits'(FixedBytes);
  assign sum_nx      = sum_q + rd_data_q;
  assign cfg_ready_o = 1'b1;
  assign s_axis_tready = (state_q == S_IDLE);
  assign wr_en = s_axis_tvalid && s_axis_tready && (fill_q < AddrBits'(StoreDepth));

  // Buffer: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= s_axis_tdata;
    end
    rd_data_q <= mem[rd_addr];
  end

  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    head_d  = head_q;
    fill_d  = fill_q;
    idx_d   = idx_q;
    addr_d  = addr_q;
    id_d    = id_q;
    len_d   = len_q;
    sum_d   = sum_q;
    add_d   = add_q;
    chks_d  = chks_q;
    chka_d  = chka_q;
    pos_d   = pos_q;
    wcnt_d  = wcnt_q;
    word_d  = word_q;
    last_d  = last_q;
    rej_d   = rej_q;
    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          if (wr_en) fill_d = fill_q + 1'b1;
          state_d = S_SCAN;
          phase_d = 1'b0;
          idx_d   = '0;
        end
      end
      S_SCAN: begin
        if (!phase_q) begin
          if (fill_q == '0) state_d = S_IDLE;
          else phase_d = 1'b1;
        end else begin
          phase_d = 1'b0;
          if (rd_data_q == sync_q) begin
            state_d = S_HDR;
            idx_d   = AddrBits'(1);
          end else begin
            // drop a byte that is not the sync byte
            head_d = head_q + 1'b1;
            fill_d = fill_q - 1'b1;
          end
        end
      end
      S_HDR: begin
        if (!phase_q) begin
          if (fill_q < AddrBits'(HdrBytes)) state_d = S_IDLE;
          else phase_d = 1'b1;
        end else begin
          phase_d = 1'b0;
          idx_d   = idx_q + 1'b1;
          if (idx_q == AddrBits'(1)) addr_d = rd_data_q;
          else if (idx_q == AddrBits'(2)) id_d = rd_data_q;
          else begin
            len_d = rd_data_q;
            if (fill_q < data_fsize) state_d = S_IDLE;
            else begin
              state_d = S_SUM;
              idx_d   = '0;
              sum_d   = '0;
              add_d   = '0;
            end
          end
        end
      end
      S_SUM: begin
        if (!phase_q) phase_d = 1'b1;
        else begin
          phase_d = 1'b0;
          sum_d   = sum_nx;
          add_d   = add_q + sum_nx;
          idx_d   = idx_q + 1'b1;
          if (idx_q == fsize - AddrBits'(3)) state_d = S_CHK;
        end
      end
      S_CHK: begin
        if (!phase_q) phase_d = 1'b1;
        else begin
          phase_d = 1'b0;
          idx_d   = idx_q + 1'b1;
          if (idx_q == fsize - AddrBits'(2)) chks_d = rd_data_q;
          else begin
            chka_d = rd_data_q;
            if (sum_q != chks_q || add_q != rd_data_q) begin
              if (rej_q != '1) rej_d = rej_q + 1'b1;
              head_d  = head_q + 1'b1;
              fill_d  = fill_q - 1'b1;
              idx_d   = '0;
              state_d = S_SCAN;
            end else begin
              idx_d  = AddrBits'(HdrBytes);
              pos_d  = '0;
              wcnt_d = '0;
              word_d = '0;
              last_d = (len_q == '0);
              state_d = (len_q == '0) ? S_OUT : S_WORD;
            end
          end
        end
      end
      S_WORD: begin
        if (!phase_q) phase_d = 1'b1;
        else begin
          phase_d = 1'b0;
          word_d  = word_q | (64'(rd_data_q) << {wcnt_q[2:0], 3'b000});
          wcnt_d  = wcnt_q + 1'b1;
          pos_d   = pos_q + 1'b1;
          idx_d   = idx_q + 1'b1;
          last_d  = (pos_q + 1'b1 == len_q);
          if (wcnt_q == 4'd7 || pos_q + 1'b1 == len_q) state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (m_axis_tready) begin
          if (last_q) begin
            // remove the delivered frame and look for the next one
            head_d  = head_q + fsize;
            fill_d  = fill_q - fsize;
            idx_d   = '0;
            state_d = S_SCAN;
          end else begin
            wcnt_d  = '0;
            word_d  = '0;
            state_d = S_WORD;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      phase_q <= 1'b0;
      head_q  <= '0;
      fill_q  <= '0;
      idx_q   <= '0;
      rej_q   <= '0;
      sync_q  <= SyncReset;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      head_q  <= head_d;
      fill_q  <= fill_d;
      idx_q   <= idx_d;
      rej_q   <= rej_d;
      if (cfg_valid_i) sync_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q <= addr_d;
    id_q   <= id_d;
    len_q  <= len_d;
    sum_q  <= sum_d;
    add_q  <= add_d;
    chks_q <= chks_d;
    chka_q <= chka_d;
    pos_q  <= pos_d;
    wcnt_q <= wcnt_d;
    word_q <= word_d;
    last_q <= last_d;
  end

  assign m_axis_tvalid = (state_q == S_OUT);
  assign m_axis_tlast  = last_q;
  assign m_axis_tdata  = {4'b0000, 32'(rej_q), chka_q, chks_q, wcnt_q, word_q,
                          len_q, id_q, addr_q};

endmodule
`default_nettype wire

/* dv/cfd_checker.sv */
// Frame checker for the checksummed frame deframer: watches the byte, config and
// word channels, predicts the emitted words and compares them. Depends on cfd_pkg.
`timescale 1ns / 1ps
module cfd_checker
  import cfd_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_valid_i,
  input  wire logic               cfg_ready_i,
  input  wire logic [7:0]         cfg_data_i,
  input  wire logic               s_tvalid_i,
  input  wire logic               s_tready_i,
  input  wire logic [7:0]         s_tdata_i,
  input  wire logic               m_tvalid_i,
  input  wire logic               m_tready_i,
  input  wire logic [OutBits-1:0] m_tdata_i,
  input  wire logic               m_tlast_i,
  output int                      errors_o,
  output int                      pending_o
);
  typedef struct packed {
    logic        last;
    logic [OutBits-1:0] data;
  } word_t;

  logic [7:0]  rx_buf [StoreDepth];
  int unsigned held;
  logic [31:0] rejects;
  logic [7:0]  sync_val;
  word_t       words_q[$];

  assign pending_o = words_q.size();

  function automatic void drop(int unsigned k);
    if (k >= held) begin
      held = 0;
      return;
    end
    for (int unsigned i = 0; i < held - k; i++) rx_buf[i] = rx_buf[i + k];
    held -= k;
  endfunction

  // Append one byte and emit every frame it completes.
  function automatic void take_byte(logic [7:0] b);
    int unsigned pos, fsize, len, nw, cnt;
    logic [7:0] sum, add;
    logic [63:0] dw;
    word_t wd;
    if (held < StoreDepth) begin
      rx_buf[held] = b;
      held++;
    end
    forever begin
      pos = 0;
      while (pos < held && rx_buf[pos] != sync_val) pos++;
      if (pos >= held) begin
        held = 0;
        break;
      end
      drop(pos);
      if (held < HdrBytes) break;
      len = rx_buf[3];
      fsize = len + FixedBytes;
      if (held < fsize) break;
      sum = 0;
      add = 0;
      for (int unsigned i = 0; i < fsize - 2; i++) begin
        sum += rx_buf[i];
        add += sum;
      end
      if (sum != rx_buf[fsize-2] || add != rx_buf[fsize-1]) begin
        if (rejects != '1) rejects++;
        drop(1);
        continue;
      end
      nw = (len == 0) ? 1 : (len + 7) / 8;
      for (int unsigned w = 0; w < nw; w++) begin
        cnt = (len > w * 8) ? len - w * 8 : 0;
        if (cnt > 8) cnt = 8;
        dw = '0;
        for (int unsigned i = 0; i < cnt; i++) dw[8*i +: 8] = rx_buf[4 + w*8 + i];
        wd.data = {4'b0, rejects, rx_buf[fsize-1], rx_buf[fsize-2], cnt[3:0], dw,
                   len[7:0], rx_buf[2], rx_buf[1]};
        wd.last = (w + 1 == nw);
        words_q = {words_q, wd};
      end
      drop(fsize);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    word_t exp_w;
    if (!rst_ni) begin
      held = 0;
      rejects = '0;
      sync_val = SyncReset;
      errors_o <= 0;
      words_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) sync_val = cfg_data_i;
      if (m_tvalid_i && m_tready_i) begin
        if (words_q.size() == 0) begin
          $display("%0t: unexpected word %h last %b", $time, m_tdata_i, m_tlast_i);
          errors_o <= errors_o + 1;
        end else begin
          exp_w = words_q.pop_front();
          if (exp_w.data !== m_tdata_i || exp_w.last !== m_tlast_i) begin
            $display("%0t: word mismatch expected %h last %b actual %h last %b",
                     $time, exp_w.data, exp_w.last, m_tdata_i, m_tlast_i);
            errors_o <= errors_o + 1;
          end
        end
      end
      if (s_tvalid_i && s_tready_i) take_byte(s_tdata_i);
    end
  end
endmodule

/* dv/testbench.sv */
// Top of the deframer testbench: clock, reset, frame stimulus and verdict.
// Depends on cfd_pkg, checksummed_frame_deframer and cfd_checker.
`timescale 1ns / 1ps
module testbench
  import cfd_pkg::*;
();

  localparam int StallLimit = 200000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic [7:0] cfg_data_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic [7:0] s_axis_tdata = '0;
  logic m_axis_tready = 1'b0;
  logic cfg_ready_o, s_axis_tready, m_axis_tvalid, m_axis_tlast;
  logic [OutBits-1:0] m_axis_tdata;
  int errors, pending;

  // Idle rates in percent; hold_off forces a long receiver stall.
  int send_idle = 31, recv_idle = 79;
  bit hold_off = 1'b0;
  logic [7:0] sync_now = SyncReset;
  byte unsigned stream_q[$];
  int idle_cycles = 0;

  always #1 clk_i = ~clk_i;

  checksummed_frame_deframer u_dut (.*);

  cfd_checker u_chk (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_data_i,
    .s_tvalid_i(s_axis_tvalid), .s_tready_i(s_axis_tready), .s_tdata_i(s_axis_tdata),
    .m_tvalid_i(m_axis_tvalid), .m_tready_i(m_axis_tready), .m_tdata_i(m_axis_tdata),
    .m_tlast_i(m_axis_tlast), .errors_o(errors), .pending_o(pending)
  );

  // Receiver: random back-pressure, or a hard hold when asked.
  always @(posedge clk_i) begin
    m_axis_tready <= !hold_off && ($urandom_range(99) >= recv_idle);
  end

  // Watchdog: end the run if nothing moves for too long.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > StallLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Queue a frame; optionally corrupt its sum-of-sums check byte.
  task automatic add_frame(int len, bit corrupt);
    byte unsigned fb[$];
    byte unsigned sum, add;
    sum = 0;
    add = 0;
    fb = {sync_now, 8'($urandom_range(255)), 8'($urandom_range(255)), 8'(len)};
    for (int i = 0; i < len; i++) fb = {fb, 8'($urandom_range(255))};
    foreach (fb[i]) begin
      sum += fb[i];
      add += sum;
    end
    if (corrupt) add ^= 8'h01 << $urandom_range(7);
    fb = {fb, sum, add};
    stream_q = {stream_q, fb};
  endtask

  // Send everything queued, one request per accepted byte.
  task automatic send_stream();
    while (stream_q.size() != 0) begin
      if ($urandom_range(99) < send_idle) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
      end else begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= stream_q.pop_front();
        do @(posedge clk_i); while (!s_axis_tready);
      end
    end
    s_axis_tvalid <= 1'b0;
  endtask

  // Wait until every predicted word is out and the block is idle again.
  task automatic drain();
    @(posedge clk_i);
    while (pending != 0 || !s_axis_tready) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_sync(logic [7:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sync_now = v;
  endtask

  // Random traffic: mostly good frames, some bad checks and line noise.
  task automatic random_phase(int n_bytes);
    int sent;
    sent = 0;
    while (sent < n_bytes) begin
      case ($urandom_range(9))
        0: stream_q = {stream_q, 8'($urandom_range(255))};
        1: add_frame(int'($urandom_range(12)), 1'b1);
        default: add_frame(int'($urandom_range(16)), 1'b0);
      endcase
      sent += stream_q.size();
      send_stream();
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty payload, full word, odd size, bad check, noise, max length.
    add_frame(0, 1'b0);
    add_frame(8, 1'b0);
    add_frame(3, 1'b1);
    stream_q = {stream_q, 8'h00, 8'hFF};
    add_frame(9, 1'b0);
    send_stream();
    drain();
    add_frame(255, 1'b0);
    send_stream();
    drain();

    write_sync(8'h00);
    random_phase(20);
    drain();

    // Swap idle rates; long receiver hold while frames keep coming.
    send_idle = 79;
    recv_idle = 31;
    write_sync(8'hFF);
    fork
      random_phase(20);
      begin
        hold_off = 1'b1;
        repeat (3000) @(posedge clk_i);
        hold_off = 1'b0;
      end
    join
    drain();

    send_idle = 0;
    recv_idle = 0;
    write_sync(8'($urandom_range(255)));
    random_phase(12);
    drain();
    write_sync(SyncReset);
    random_phase(8);
    drain();

    if (errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end
endmodule
